[rtl/pitp_pkg.sv]
// ----------------------------------------------------------------------------
// pitp_pkg
// Shared widths, types and stage indexes for the 3D point-in-polygon pipeline.
// ----------------------------------------------------------------------------
package pitp_pkg;

   localparam int COORD_BITS = 20;
   localparam int FIELD_BITS = 60;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int MUL1_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = 2 * COORD_BITS + 3;
   localparam int LO_BITS    = (CROSS_BITS + 1) / 2;
   localparam int HI_BITS    = CROSS_BITS - LO_BITS;
   localparam int DOT_BITS   = 2 * CROSS_BITS + 2;

   localparam int NUM_AXES  = 3;
   localparam int NUM_VERTS = 4;
   localparam int NUM_DOTS  = 4;

   // vector element order
   localparam int AX_X = 0;
   localparam int AX_Y = 1;
   localparam int AX_Z = 2;

   // polygon kind
   localparam logic FUNC_TRI  = 1'b0;
   localparam logic FUNC_QUAD = 1'b1;

   // pipeline stages
   localparam int ST_DIFF    = 0;
   localparam int ST_CROSS   = 1;
   localparam int ST_PART    = 2;
   localparam int ST_PROD    = 3;
   localparam int ST_SIGN    = 4;
   localparam int NUM_STAGES = 5;

   typedef logic [FIELD_BITS-1:0]        field_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef diff_type [NUM_AXES-1:0]      diff_vec_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef cross_type [NUM_AXES-1:0]     cross_vec_type;
   typedef logic [NUM_STAGES-1:0]        stage_vec_type;

   typedef struct packed {
      stage_vec_type load;
      stage_vec_type busy;
   } pipe_ctl_type;

endpackage

[rtl/pitp_ifs.sv]
// ----------------------------------------------------------------------------
// pitp request / response interfaces
// Valid/ready channels carrying the query item and the inside flag.
// ----------------------------------------------------------------------------
interface pitp_req_if;
   import pitp_pkg::*;

   logic      valid;
   logic      ready;
   logic      func;
   field_type query_point;
   field_type vertex_a;
   field_type vertex_b;
   field_type vertex_c;
   field_type vertex_d;

   modport source (
      output valid, func, query_point, vertex_a, vertex_b, vertex_c, vertex_d,
      input  ready
   );
   modport sink (
      input  valid, func, query_point, vertex_a, vertex_b, vertex_c, vertex_d,
      output ready
   );
endinterface

interface pitp_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink (input valid, inside_res, output ready);
endinterface

[rtl/pitp_ctl.sv]
// ----------------------------------------------------------------------------
// pitp_ctl
// Per-stage valid bits and load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module pitp_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pitp_pkg::pipe_ctl_type ctl
);
   import pitp_pkg::*;

   stage_vec_type         vld_ff;
   stage_vec_type         vld_in;
   logic [NUM_STAGES:0]   take;
   stage_vec_type         src;
   logic                  in_xfer;
   logic                  out_xfer;

   // a stage may load when it is empty or its content moves on
   always_comb begin
      take[NUM_STAGES] = out_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         take[k] = !vld_ff[k] || take[k+1];
      end
      src = {vld_ff[NUM_STAGES-2:0], in_valid};
      for (int k = 0; k < NUM_STAGES; k++) begin
         vld_in[k] = take[k] ? src[k] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready  = take[0];
   assign out_valid = vld_ff[NUM_STAGES-1];
   assign ctl.load  = take[NUM_STAGES-1:0];
   assign ctl.busy  = vld_ff;
   assign in_xfer   = in_valid && take[0];
   assign out_xfer  = vld_ff[NUM_STAGES-1] && out_ready;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_PROD] && !take[ST_PROD]) |=> vld_ff[ST_PROD])
      else $error("stalled item dropped");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[ST_DIFF] |-> in_ready)
      else $error("empty first stage refuses input");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (in_xfer && !out_xfer) |=> $countones(vld_ff) == $past($countones(vld_ff)) + 1)
      else $error("item count not incremented");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (out_xfer && !in_xfer) |=> $countones(vld_ff) == $past($countones(vld_ff)) - 1)
      else $error("item count not decremented");

endmodule

[rtl/pitp_cross.sv]
// ----------------------------------------------------------------------------
// pitp_cross
// Stage 1: edge vectors from each vertex to the point.
// Stage 2: cross products of consecutive edge vectors.
// ----------------------------------------------------------------------------
module pitp_cross (
   input  logic                    clock,
   input  pitp_pkg::pipe_ctl_type  ctl,
   input  logic                    func,
   input  pitp_pkg::field_type     query_point,
   input  pitp_pkg::field_type     vertex_a,
   input  pitp_pkg::field_type     vertex_b,
   input  pitp_pkg::field_type     vertex_c,
   input  pitp_pkg::field_type     vertex_d,
   output logic                    func_out,
   output pitp_pkg::cross_vec_type u_vec,
   output pitp_pkg::cross_vec_type v_vec,
   output pitp_pkg::cross_vec_type w_vec,
   output pitp_pkg::cross_vec_type t_vec
);
   import pitp_pkg::*;

   // bits above the 60-bit field read as zero
   function automatic coord_type coord_at(field_type field, int slot);
      logic [FIELD_BITS+3*COORD_BITS-1:0] ext;
      ext = {{(3*COORD_BITS){1'b0}}, field};
      return coord_type'(ext[slot*COORD_BITS +: COORD_BITS]);
   endfunction

   function automatic cross_type cross_term(diff_type a, diff_type b,
                                            diff_type c, diff_type d);
      logic signed [MUL1_BITS-1:0] p1;
      logic signed [MUL1_BITS-1:0] p2;
      p1 = a * b;
      p2 = c * d;
      return CROSS_BITS'(p1) - CROSS_BITS'(p2);
   endfunction

   function automatic cross_vec_type cross_prod(diff_vec_type a, diff_vec_type b);
      cross_vec_type c;
      c[AX_X] = cross_term(a[AX_Y], b[AX_Z], a[AX_Z], b[AX_Y]);
      c[AX_Y] = cross_term(a[AX_Z], b[AX_X], a[AX_X], b[AX_Z]);
      c[AX_Z] = cross_term(a[AX_X], b[AX_Y], a[AX_Y], b[AX_X]);
      return c;
   endfunction

   field_type     verts [NUM_VERTS];
   diff_vec_type  e_in  [NUM_VERTS];
   diff_vec_type  e_ff  [NUM_VERTS];
   diff_vec_type  ew_in;
   diff_vec_type  ew_ff;
   logic          func1_ff;
   logic          func2_ff;
   cross_vec_type u_ff, v_ff, w_ff, t_ff;

   assign verts[0] = vertex_a;
   assign verts[1] = vertex_b;
   assign verts[2] = vertex_c;
   assign verts[3] = vertex_d;

   always_comb begin
      for (int vi = 0; vi < NUM_VERTS; vi++) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            // x sits in the top slot, z in the bottom one
            e_in[vi][ax] = DIFF_BITS'(coord_at(query_point, 2 - ax))
                         - DIFF_BITS'(coord_at(verts[vi], 2 - ax));
         end
      end
      // triangle closes back on the first edge, quad on the fourth
      ew_in = (func == FUNC_QUAD) ? e_in[3] : e_in[0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_DIFF]) begin
         e_ff     <= e_in;
         ew_ff    <= ew_in;
         func1_ff <= func;
      end
      if (ctl.load[ST_CROSS]) begin
         u_ff     <= cross_prod(e_ff[0], e_ff[1]);
         v_ff     <= cross_prod(e_ff[1], e_ff[2]);
         w_ff     <= cross_prod(e_ff[2], ew_ff);
         t_ff     <= cross_prod(e_ff[3], e_ff[0]);
         func2_ff <= func1_ff;
      end
   end

   assign func_out = func2_ff;
   assign u_vec    = u_ff;
   assign v_vec    = v_ff;
   assign w_vec    = w_ff;
   assign t_vec    = t_ff;

endmodule

[rtl/pitp_dot.sv]
// ----------------------------------------------------------------------------
// pitp_dot
// Stage 3: split partial products of the dot-product terms.
// Stage 4: recombined full-width products.
// Stage 5: sums, sign tests and the inside flag.
// ----------------------------------------------------------------------------
module pitp_dot (
   input  logic                    clock,
   input  pitp_pkg::pipe_ctl_type  ctl,
   input  logic                    func,
   input  pitp_pkg::cross_vec_type u_vec,
   input  pitp_pkg::cross_vec_type v_vec,
   input  pitp_pkg::cross_vec_type w_vec,
   input  pitp_pkg::cross_vec_type t_vec,
   output logic                    inside_res
);
   import pitp_pkg::*;

   typedef logic signed [2*HI_BITS-1:0]         hh_type;
   typedef logic signed [HI_BITS+LO_BITS:0]     hl_type;
   typedef logic [2*LO_BITS-1:0]                ll_type;
   typedef logic signed [DOT_BITS-1:0]          dot_type;

   cross_vec_type lhs [NUM_DOTS];
   cross_vec_type rhs [NUM_DOTS];

   hh_type  hh_in [NUM_DOTS][NUM_AXES];
   hl_type  hl_in [NUM_DOTS][NUM_AXES];
   hl_type  lh_in [NUM_DOTS][NUM_AXES];
   ll_type  ll_in [NUM_DOTS][NUM_AXES];
   hh_type  hh_ff [NUM_DOTS][NUM_AXES];
   hl_type  hl_ff [NUM_DOTS][NUM_AXES];
   hl_type  lh_ff [NUM_DOTS][NUM_AXES];
   ll_type  ll_ff [NUM_DOTS][NUM_AXES];
   logic    func3_ff;

   dot_type prod_in [NUM_DOTS][NUM_AXES];
   dot_type prod_ff [NUM_DOTS][NUM_AXES];
   logic    func4_ff;

   logic [NUM_DOTS-1:0] neg;
   logic                inside_in;
   logic                inside_ff;

   // triangle: U.V and U.W; quad: U.V, V.W, W.T and T.U
   always_comb begin
      lhs[0] = u_vec;
      rhs[0] = v_vec;
      lhs[1] = (func == FUNC_QUAD) ? v_vec : u_vec;
      rhs[1] = w_vec;
      lhs[2] = w_vec;
      rhs[2] = t_vec;
      lhs[3] = t_vec;
      rhs[3] = u_vec;
   end

   // operand = hi * 2^LO + lo, hi signed, lo unsigned
   always_comb begin
      logic signed [HI_BITS-1:0] ah;
      logic signed [HI_BITS-1:0] bh;
      logic [LO_BITS-1:0]        al;
      logic [LO_BITS-1:0]        bl;
      for (int d = 0; d < NUM_DOTS; d++) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            ah = lhs[d][ax][CROSS_BITS-1:LO_BITS];
            bh = rhs[d][ax][CROSS_BITS-1:LO_BITS];
            al = lhs[d][ax][LO_BITS-1:0];
            bl = rhs[d][ax][LO_BITS-1:0];
            hh_in[d][ax] = ah * bh;
            hl_in[d][ax] = ah * signed'({1'b0, bl});
            lh_in[d][ax] = bh * signed'({1'b0, al});
            ll_in[d][ax] = al * bl;
         end
      end
   end

   always_comb begin
      dot_type t_hh;
      dot_type t_hl;
      dot_type t_lh;
      dot_type t_ll;
      for (int d = 0; d < NUM_DOTS; d++) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            t_hh = DOT_BITS'(hh_ff[d][ax]) <<< (2 * LO_BITS);
            t_hl = DOT_BITS'(hl_ff[d][ax]) <<< LO_BITS;
            t_lh = DOT_BITS'(lh_ff[d][ax]) <<< LO_BITS;
            t_ll = dot_type'({{(DOT_BITS-2*LO_BITS){1'b0}}, ll_ff[d][ax]});
            prod_in[d][ax] = t_hh + t_hl + t_lh + t_ll;
         end
      end
   end

   always_comb begin
      dot_type sum;
      for (int d = 0; d < NUM_DOTS; d++) begin
         sum    = prod_ff[d][AX_X] + prod_ff[d][AX_Y] + prod_ff[d][AX_Z];
         neg[d] = sum[DOT_BITS-1];
      end
      // zero counts as inside
      inside_in = !(neg[0] || neg[1] ||
                    ((func4_ff == FUNC_QUAD) && (neg[2] || neg[3])));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_PART]) begin
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         lh_ff    <= lh_in;
         ll_ff    <= ll_in;
         func3_ff <= func;
      end
      if (ctl.load[ST_PROD]) begin
         prod_ff  <= prod_in;
         func4_ff <= func3_ff;
      end
      if (ctl.load[ST_SIGN]) begin
         inside_ff <= inside_in;
      end
   end

   assign inside_res = inside_ff;

endmodule

[rtl/point_in_3d_polygon_test.sv]
// ----------------------------------------------------------------------------
// point_in_3d_polygon_test
// Same-side test of a 3D point against a triangle or a quad.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one query per transfer: func (0 triangle on vertices
//   a, b, c; 1 quad on a, b, c, d), the query point and the vertices, each
//   packed as signed x, y, z coordinates of COORD_BITS bits.
//   rsp_chan returns one inside_res bit per query, in order: 1 when no tested
//   dot product of neighboring edge cross products is negative, so points on
//   an edge and degenerate polygons count as inside.
//   From the request transfer to the response, each query passes the
//   registered stages edge vectors, cross products, split partial products,
//   full products, and the sign test in the output register. One query per
//   cycle is sustained while rsp_chan.ready stays high; the split 43x43
//   multipliers are pipelined so each stage holds one product level.
//   Reset clears all stage valid bits; no query is in flight afterward.
//   When the receiver holds rsp_chan.ready low, the result stays in the
//   output register and earlier stages keep filling their empty slots, so
//   req_chan.ready drops only once every stage holds a query.
// ----------------------------------------------------------------------------
module point_in_3d_polygon_test (
   input  logic       clock,
   input  logic       reset,
   pitp_req_if.sink   req_chan,
   pitp_rsp_if.source rsp_chan
);
   import pitp_pkg::*;

   pipe_ctl_type  ctl;
   logic          func_x;
   cross_vec_type u_vec, v_vec, w_vec, t_vec;

   pitp_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   pitp_cross u_cross (
      .clock       (clock),
      .ctl         (ctl),
      .func        (req_chan.func),
      .query_point (req_chan.query_point),
      .vertex_a    (req_chan.vertex_a),
      .vertex_b    (req_chan.vertex_b),
      .vertex_c    (req_chan.vertex_c),
      .vertex_d    (req_chan.vertex_d),
      .func_out    (func_x),
      .u_vec       (u_vec),
      .v_vec       (v_vec),
      .w_vec       (w_vec),
      .t_vec       (t_vec)
   );

   pitp_dot u_dot (
      .clock      (clock),
      .ctl        (ctl),
      .func       (func_x),
      .u_vec      (u_vec),
      .v_vec      (v_vec),
      .w_vec      (w_vec),
      .t_vec      (t_vec),
      .inside_res (rsp_chan.inside_res)
   );

endmodule

[sim/point_in_3d_polygon_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_3d_polygon_test_tb
// Streams triangle and quad same-side queries through the block and checks
// every inside flag against a full-width integer prediction, in order, with
// random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module point_in_3d_polygon_test_tb;
   import pitp_pkg::*;

   localparam int CMAX   = 2 ** (COORD_BITS - 1) - 1;
   localparam int CMIN   = -(2 ** (COORD_BITS - 1));
   localparam int SLOT_X = 2;
   localparam int SLOT_Y = 1;
   localparam int SLOT_Z = 0;

   typedef struct packed {
      int   tag;
      logic inside_exp;
   } verdict_type;

   typedef struct packed {
      int x;
      int y;
      int z;
   } grid_vec_type;

   logic clock;
   logic reset;

   pitp_req_if req_bus ();
   pitp_rsp_if rsp_bus ();

   point_in_3d_polygon_test u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   verdict_type pending_verdicts[$];
   verdict_type head_verdict;
   int          query_count;
   int          err_count;
   bit          tx_gaps_on;
   bit          rx_stalls_on;
   int          rx_hold;

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------
   function automatic longint coord_of(field_type f, int slot);
      coord_type c;
      c = f[slot*COORD_BITS +: COORD_BITS];
      return c;
   endfunction

   function automatic logic dot_is_negative(longint ax, longint ay, longint az,
                                            longint bx, longint by, longint bz);
      logic signed [127:0] wax, way, waz, wbx, wby, wbz, sum;
      wax = 128'(ax); way = 128'(ay); waz = 128'(az);
      wbx = 128'(bx); wby = 128'(by); wbz = 128'(bz);
      sum = wax * wbx + way * wby + waz * wbz;
      return sum[127];
   endfunction

   function automatic logic predict_inside(logic kind, field_type p, field_type a,
                                           field_type b, field_type c, field_type d);
      field_type vtx[4];
      longint    ex[4], ey[4], ez[4];
      longint    cx[4], cy[4], cz[4];
      int        n, i, j;
      logic      outside;
      vtx[0] = a; vtx[1] = b; vtx[2] = c; vtx[3] = d;
      n = (kind == FUNC_QUAD) ? 4 : 3;
      for (i = 0; i < n; i++) begin
         ex[i] = coord_of(p, SLOT_X) - coord_of(vtx[i], SLOT_X);
         ey[i] = coord_of(p, SLOT_Y) - coord_of(vtx[i], SLOT_Y);
         ez[i] = coord_of(p, SLOT_Z) - coord_of(vtx[i], SLOT_Z);
      end
      // cross of each edge vector with the next one around the polygon
      for (i = 0; i < n; i++) begin
         j = (i + 1) % n;
         cx[i] = ey[i] * ez[j] - ez[i] * ey[j];
         cy[i] = ez[i] * ex[j] - ex[i] * ez[j];
         cz[i] = ex[i] * ey[j] - ey[i] * ex[j];
      end
      outside = 1'b0;
      if (kind == FUNC_QUAD) begin
         for (i = 0; i < 4; i++) begin
            j = (i + 1) % 4;
            if (dot_is_negative(cx[i], cy[i], cz[i], cx[j], cy[j], cz[j]))
               outside = 1'b1;
         end
      end else begin
         // triangle: only U.V and U.W are looked at
         if (dot_is_negative(cx[0], cy[0], cz[0], cx[1], cy[1], cz[1]) ||
             dot_is_negative(cx[0], cy[0], cz[0], cx[2], cy[2], cz[2]))
            outside = 1'b1;
      end
      return !outside;
   endfunction

   // ---------------------------------------------------------------------
   // helpers
   // ---------------------------------------------------------------------
   function automatic field_type pack_pt(int x, int y, int z);
      return {coord_type'(x), coord_type'(y), coord_type'(z)};
   endfunction

   function automatic int rand_in(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(0, 5))
         0: return CMIN;
         1: return CMAX;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return rand_in(CMIN, CMAX);
      endcase
   endfunction

   function automatic field_type plane_pt(grid_vec_type o, grid_vec_type u,
                                          grid_vec_type v, int s, int t);
      return pack_pt(o.x + s * u.x + t * v.x, o.y + s * u.y + t * v.y,
                     o.z + s * u.z + t * v.z);
   endfunction

   task automatic report_mismatch(string msg);
      err_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   task automatic send_query(logic kind, field_type p, field_type a, field_type b,
                             field_type c, field_type d);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.func        = kind;
      req_bus.query_point = p;
      req_bus.vertex_a    = a;
      req_bus.vertex_b    = b;
      req_bus.vertex_c    = c;
      req_bus.vertex_d    = d;
      req_bus.valid       = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      pending_verdicts.push_back('{query_count, predict_inside(kind, p, a, b, c, d)});
      query_count++;
   endtask

   task automatic release_request();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_all_results();
      release_request();
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_query();
      grid_vec_type o, u, v;
      int           s[4], t[4];
      int           r, i;
      logic         kind;
      field_type    p, a, b, c, d;
      kind = 1'($urandom_range(0, 1));
      r    = $urandom_range(0, 99);
      if (r < 70) begin
         // points on a common plane, polygon parallelogram or loose triangle
         o = '{rand_in(-131072, 131071), rand_in(-131072, 131071),
               rand_in(-131072, 131071)};
         u = '{rand_in(-32, 32), rand_in(-32, 32), rand_in(-32, 32)};
         v = '{rand_in(-32, 32), rand_in(-32, 32), rand_in(-32, 32)};
         if (kind == FUNC_QUAD) begin
            s[0] = rand_in(-100, 0); s[1] = rand_in(1, 100);
            t[0] = rand_in(-100, 0); t[2] = rand_in(1, 100);
            s[2] = s[1]; s[3] = s[0]; t[1] = t[0]; t[3] = t[2];
         end else begin
            for (i = 0; i < 4; i++) begin
               s[i] = rand_in(-100, 100);
               t[i] = rand_in(-100, 100);
            end
         end
         a = plane_pt(o, u, v, s[0], t[0]);
         b = plane_pt(o, u, v, s[1], t[1]);
         c = plane_pt(o, u, v, s[2], t[2]);
         d = plane_pt(o, u, v, s[3], t[3]);
         case ($urandom_range(0, 9))
            0: p = a;
            1: p = plane_pt(o, u, v, s[1], (t[1] + t[2]) / 2);
            default: p = plane_pt(o, u, v, rand_in(-120, 120), rand_in(-120, 120));
         endcase
         if (r >= 55)
            p = pack_pt(int'(coord_of(p, SLOT_X)) + rand_in(-5, 5),
                        int'(coord_of(p, SLOT_Y)) + rand_in(-5, 5),
                        int'(coord_of(p, SLOT_Z)) + rand_in(-5, 5));
         if ($urandom_range(0, 1)) begin
            // opposite winding
            if (kind == FUNC_QUAD) {b, d} = {d, b};
            else {b, c} = {c, b};
         end
      end else if (r < 85) begin
         p = pack_pt(extreme_coord(), extreme_coord(), extreme_coord());
         a = pack_pt(extreme_coord(), extreme_coord(), extreme_coord());
         b = pack_pt(extreme_coord(), extreme_coord(), extreme_coord());
         c = pack_pt(extreme_coord(), extreme_coord(), extreme_coord());
         d = pack_pt(extreme_coord(), extreme_coord(), extreme_coord());
      end else begin
         p = field_type'({$urandom, $urandom});
         a = field_type'({$urandom, $urandom});
         b = field_type'({$urandom, $urandom});
         c = field_type'({$urandom, $urandom});
         d = field_type'({$urandom, $urandom});
      end
      send_query(kind, p, a, b, c, d);
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      rx_hold       = 0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rx_hold--;
         end else if (!rx_stalls_on) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 2) != 0);
            rx_hold       = rsp_bus.ready ? $urandom_range(0, 8) : pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("inside_res %0b with no query outstanding",
                                      rsp_bus.inside_res));
         end else begin
            head_verdict = pending_verdicts.pop_front();
            if (rsp_bus.inside_res !== head_verdict.inside_exp)
               report_mismatch($sformatf("query %0d: inside_res %b, predicted %b",
                                         head_verdict.tag, rsp_bus.inside_res,
                                         head_verdict.inside_exp));
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_triangle_directed();
      field_type a, b, c, junk;
      a    = pack_pt(0, 0, 0);
      b    = pack_pt(100, 0, 0);
      c    = pack_pt(0, 100, 0);
      junk = '1;
      send_query(FUNC_TRI, pack_pt(20, 20, 0), a, b, c, junk);
      send_query(FUNC_TRI, pack_pt(200, 200, 0), a, b, c, junk);
      send_query(FUNC_TRI, pack_pt(50, 0, 0), a, b, c, junk);       // on an edge
      send_query(FUNC_TRI, a, a, b, c, junk);                        // on a corner
      send_query(FUNC_TRI, pack_pt(20, 20, 77), a, b, c, junk);
      send_query(FUNC_TRI, pack_pt(-1, 50, 0), a, b, c, junk);
      send_query(FUNC_TRI, pack_pt(20, 20, 0), a, c, b, '0);         // reversed order
      send_query(FUNC_TRI, pack_pt(9, 9, 9), pack_pt(5, 5, 5), pack_pt(5, 5, 5),
                 pack_pt(5, 5, 5), junk);                            // all vertices equal
      send_query(FUNC_TRI, pack_pt(3, -7, 1), pack_pt(0, 0, 0), pack_pt(10, 10, 10),
                 pack_pt(20, 20, 20), junk);                         // collinear
      send_query(FUNC_TRI, pack_pt(CMAX, CMAX, CMAX), pack_pt(CMIN, CMIN, CMIN),
                 pack_pt(CMAX, CMIN, CMIN), pack_pt(CMIN, CMAX, CMIN), junk);
      send_query(FUNC_TRI, pack_pt(CMIN, CMIN, CMAX), pack_pt(CMAX, CMAX, CMAX),
                 pack_pt(CMIN, CMAX, CMIN), pack_pt(CMAX, CMIN, CMIN), junk);
      send_query(FUNC_TRI, '0, '1, pack_pt(CMAX, 0, CMIN), pack_pt(0, CMIN, CMAX), '0);
   endtask

   task automatic test_quad_directed();
      field_type q0, q1, q2, q3;
      q0 = pack_pt(0, 0, 5);
      q1 = pack_pt(100, 0, 5);
      q2 = pack_pt(100, 100, 5);
      q3 = pack_pt(0, 100, 5);
      send_query(FUNC_QUAD, pack_pt(50, 50, 5), q0, q1, q2, q3);
      send_query(FUNC_QUAD, pack_pt(150, 50, 5), q0, q1, q2, q3);
      send_query(FUNC_QUAD, pack_pt(100, 50, 5), q0, q1, q2, q3);   // on an edge
      send_query(FUNC_QUAD, q2, q0, q1, q2, q3);                     // on a corner
      send_query(FUNC_QUAD, pack_pt(50, 50, 5), q0, q3, q2, q1);
      send_query(FUNC_QUAD, pack_pt(50, 50, 5), q0, q2, q1, q3);    // self-crossing
      send_query(FUNC_QUAD, pack_pt(90, 50, 5), q0, q2, q1, q3);
      send_query(FUNC_QUAD, pack_pt(50, 50, -300), q0, q1, q2, q3);
      send_query(FUNC_QUAD, pack_pt(1, 2, 3), q1, q1, q1, q1);
      send_query(FUNC_QUAD, pack_pt(CMAX, CMAX, CMAX), pack_pt(CMIN, CMIN, CMIN),
                 pack_pt(CMAX, CMIN, CMIN), pack_pt(CMAX, CMAX, CMIN),
                 pack_pt(CMIN, CMAX, CMIN));
      send_query(FUNC_QUAD, pack_pt(0, 0, CMAX), pack_pt(CMIN, CMIN, CMIN),
                 pack_pt(CMAX, CMIN, CMIN), pack_pt(CMAX, CMAX, CMIN),
                 pack_pt(CMIN, CMAX, CMIN));
   endtask

   task automatic test_random_stream();
      int chunk, k;
      for (chunk = 0; chunk < 11; chunk++) begin
         tx_gaps_on   = (chunk == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         rx_stalls_on = (chunk == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         for (k = 0; k < 100; k++) send_random_query();
      end
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   task automatic test_back_to_back();
      int k;
      wait_all_results();
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      for (k = 0; k < 200; k++) send_random_query();
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   // sender holds off until the pipeline has emptied between bursts
   task automatic test_bursts_with_drain();
      int burst, k;
      for (burst = 0; burst < 10; burst++) begin
         for (k = 0; k < 20; k++) send_random_query();
         wait_all_results();
      end
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      err_count           = 0;
      query_count         = 0;
      tx_gaps_on          = 1'b1;
      rx_stalls_on        = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_TRI;
      req_bus.query_point = '0;
      req_bus.vertex_a    = '0;
      req_bus.vertex_b    = '0;
      req_bus.vertex_c    = '0;
      req_bus.vertex_d    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_triangle_directed();
      test_quad_directed();
      test_random_stream();
      test_back_to_back();
      test_bursts_with_drain();

      wait_all_results();
      repeat (10) @(posedge clock);
      if (err_count == 0 && pending_verdicts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
